// ----- rtl/slrg_pkg.sv -----
// Shared constants, types and the LCG step function for the shuffled Lehmer generator.
package slrg_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 32;
  localparam int unsigned WARM_DISCARD = 8;
  localparam int unsigned VAR_W = 31;
  localparam int unsigned SEED_W = 32;
  localparam int unsigned MULT_W = 15;
  localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
  localparam logic [VAR_W-1:0] LCG_MOD = 31'h7FFF_FFFF;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [0:0] {
    REG_SEED_VALUE = 1'b0,
    REG_UNUSED     = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WARM_INIT,
    ST_WARM_RUN,
    ST_IDX_EST,
    ST_IDX_FIX,
    ST_READ,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic warm_init;
    logic warm_step;
    logic idx_est;
    logic idx_fix;
    logic tbl_read;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic lo_zero;
    logic warm_last;
    logic out_free;
  } dp_status_t;

  // 16807*x mod (2^31-1): fold the high part of the product onto the low part.
  function automatic logic [VAR_W-1:0] lcg_step(input logic [VAR_W-1:0] x);
    logic [VAR_W+MULT_W-1:0] p;
    logic [VAR_W:0] s;
    logic [VAR_W:0] r;
    p = {{MULT_W{1'b0}}, x} * {{VAR_W{1'b0}}, LCG_MULT};
    s = {1'b0, p[VAR_W-1:0]} + {{(VAR_W+1-MULT_W){1'b0}}, p[VAR_W+MULT_W-1:VAR_W]};
    r = (s >= {1'b0, LCG_MOD}) ? (s - {1'b0, LCG_MOD}) : s;
    return r[VAR_W-1:0];
  endfunction

endpackage

// ----- rtl/slrg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module slrg_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/slrg_ctrl.sv -----
// Controller state machine: warm-up sequencing and per-word step sequencing.
module slrg_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   reseed,
  output logic                   s_tready,
  input  slrg_pkg::dp_status_t   status,
  output slrg_pkg::dp_cmd_t      cmd
);

  import slrg_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (reseed || status.lo_zero) ? ST_WARM_INIT : ST_IDX_EST;
        end
      end
      ST_WARM_INIT: state_next = ST_WARM_RUN;
      ST_WARM_RUN: begin
        if (status.warm_last) begin
          state_next = ST_IDX_EST;
        end
      end
      ST_IDX_EST: state_next = ST_IDX_FIX;
      ST_IDX_FIX: state_next = ST_READ;
      ST_READ: state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE:      s_tready = 1'b1;
      ST_WARM_INIT: cmd.warm_init = 1'b1;
      ST_WARM_RUN:  cmd.warm_step = 1'b1;
      ST_IDX_EST:   cmd.idx_est = 1'b1;
      ST_IDX_FIX:   cmd.idx_fix = 1'b1;
      ST_READ:      cmd.tbl_read = 1'b1;
      ST_UPDATE:    cmd.update = status.out_free;
      default:      s_tready = 1'b0;
    endcase
  end

endmodule

// ----- rtl/slrg_dp.sv -----
// Datapath: LCG state, warm-up counter, table index unit, shuffle table and output register.
module slrg_dp #(
  parameter int unsigned TABLE_DEPTH = slrg_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [slrg_pkg::SEED_W-1:0]  seed_value,
  input  slrg_pkg::dp_cmd_t            cmd,
  output slrg_pkg::dp_status_t         status,
  input  logic                         m_tready,
  output logic                         m_tvalid,
  output logic [slrg_pkg::VAR_W-1:0]   variate
);

  import slrg_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned QW = $clog2(TABLE_DEPTH + 2);
  localparam int unsigned TOTAL = TABLE_DEPTH + WARM_DISCARD;
  localparam int unsigned JW = $clog2(TOTAL);
  localparam longint unsigned DIV = 1 + (64'd2147483646 / TABLE_DEPTH);
  localparam longint unsigned RECIP = (64'd1 << VAR_W) / DIV;
  localparam logic [VAR_W-1:0] DIV_V = DIV[VAR_W-1:0];
  localparam logic [QW-1:0] RECIP_Q = RECIP[QW-1:0];
  localparam logic [QW-1:0] DEPTH_Q = QW'(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
  localparam logic [JW-1:0] J_START = JW'(TOTAL - 1);
  localparam logic [JW-1:0] J_DEPTH = JW'(TABLE_DEPTH);

  logic [VAR_W-1:0] lcg_state;
  logic [VAR_W-1:0] last_output;
  logic [JW-1:0]    j;
  logic [QW-1:0]    qest;
  logic [IW-1:0]    idx;

  logic [VAR_W-1:0] x_step;
  logic [SEED_W-1:0] mag;
  logic [SEED_W-1:0] red;
  logic [VAR_W+QW-1:0] est_prod;
  logic [QW-1:0]    q1;
  logic [VAR_W+QW-1:0] bound;
  logic [QW-1:0]    qfix;

  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  logic [VAR_W-1:0] ram_wdata;
  logic [VAR_W-1:0] ram_rdata;

  assign x_step = lcg_step(lcg_state);

  // start value: magnitude of a negative seed, else one; reduced below the modulus
  assign mag = seed_value[SEED_W-1] ? (~seed_value + 32'd1) : 32'd1;
  assign red = (mag >= {1'b0, LCG_MOD}) ? (mag - {1'b0, LCG_MOD}) : mag;

  assign est_prod = {{QW{1'b0}}, last_output} * {{VAR_W{1'b0}}, RECIP_Q};
  assign q1 = qest + 1'b1;
  assign bound = {{VAR_W{1'b0}}, q1} * {{QW{1'b0}}, DIV_V};
  assign qfix = ({{QW{1'b0}}, last_output} >= bound) ? q1 : qest;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_state <= '0;
      last_output <= '0;
      j <= '0;
    end else begin
      if (cmd.warm_init) begin
        lcg_state <= red[VAR_W-1:0];
        j <= J_START;
      end
      if (cmd.warm_step) begin
        lcg_state <= x_step;
        j <= j - 1'b1;
        if (j == '0) begin
          last_output <= x_step;
        end
      end
      if (cmd.tbl_read) begin
        lcg_state <= x_step;
      end
      if (cmd.update) begin
        last_output <= ram_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_est) begin
      qest <= est_prod[VAR_W+QW-1:VAR_W];
    end
    if (cmd.idx_fix) begin
      idx <= (qfix >= DEPTH_Q) ? LAST_IDX : qfix[IW-1:0];
    end
    if (cmd.update) begin
      variate <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.update) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    if (cmd.warm_step) begin
      ram_we = (j < J_DEPTH);
      ram_waddr = j[IW-1:0];
      ram_wdata = x_step;
    end else begin
      ram_we = cmd.update;
      ram_waddr = idx;
      ram_wdata = lcg_state;
    end
  end

  slrg_ram #(
    .WIDTH(VAR_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.tbl_read),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  assign status.lo_zero = (last_output == '0);
  assign status.warm_last = (j == '0);
  assign status.out_free = !m_tvalid || m_tready;

endmodule

// ----- rtl/shuffled_lehmer_random_generator_top.sv -----
// Top level of the shuffled Lehmer random generator: stream ports, APB seed register.
//
// Each accepted input word yields one 31-bit variate from the minimal standard generator
// (16807*x mod 2^31-1) behind a TABLE_DEPTH-entry shuffle table. A normal word goes
// from acceptance to the output register through the controller sequence: the table
// index (estimate multiply, then correction), one table RAM read, then the update,
// which waits until the output register is free. A word with reseed set, or the first
// word after reset, first runs the warm-up, one LCG step per cycle through the single
// table write port. A new word is taken only when the previous one has reached the
// output register; that register holds the result while the next word is computed.
// Write the seed register (address 0) only while idle.
module shuffled_lehmer_random_generator_top #(
  parameter int unsigned TABLE_DEPTH = slrg_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,  // [0] reseed
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [31:0]                      m_tdata,  // [30:0] variate
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [slrg_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [slrg_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [slrg_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  import slrg_pkg::*;

  logic [SEED_W-1:0] seed_value;
  reg_idx_t          reg_idx;
  dp_cmd_t           cmd;
  dp_status_t        status;
  logic [VAR_W-1:0]  variate;

  assign pready = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= '0;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_SEED_VALUE)) begin
      seed_value <= pwdata;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SEED_VALUE: prdata = seed_value;
      default:        prdata = '0;
    endcase
  end

  slrg_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .reseed  (s_tdata[0]),
    .s_tready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  slrg_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .seed_value(seed_value),
    .cmd       (cmd),
    .status    (status),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .variate   (variate)
  );

  assign m_tdata = {1'b0, variate};

endmodule
